>>> src/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // Field widths fixed by the command and result formats
  localparam int FUNC_W  = 3;
  localparam int CHAR_W  = 8;
  localparam int ARG_W   = 8;
  localparam int CCOL_W  = 7;
  localparam int CROW_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef logic [CCOL_W-1:0] ccol_t;
  typedef logic [CROW_W-1:0] crow_t;
  typedef logic [CHAR_W-1:0] char_t;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_PUT      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_MOVE     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLR_SCR  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLR_ROWS = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_TOP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_BOT = 2'd2;

  localparam logic [CFG_DATA_W-1:0] SCROLL_BOT_RST = 6'd49;

  // Character codes
  localparam char_t CHAR_SPACE     = 8'h20;
  localparam char_t CHAR_NEWLINE   = 8'h0a;
  localparam char_t CHAR_BACKSPACE = 8'h08;
  localparam char_t CHAR_DELETE    = 8'h7f;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    char_t                   char_code;
    logic signed [ARG_W-1:0] col_arg;
    logic signed [ARG_W-1:0] row_arg;
    logic signed [ARG_W-1:0] row_stop;
  } in_req_t;

  typedef struct packed {
    ccol_t cursor_col;
    crow_t cursor_row;
    char_t cell_char;
    logic  cell_valid;
  } out_rsp_t;

endpackage

`default_nettype wire

>>> src/tcw_ram.sv
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/text_console_cell_writer_top.sv
// Put char, move and unused codes go from S_IDLE to S_DONE; read cell passes S_READ first.
// Clear screen and clear rows fill cells in S_FILL; a scrolling line feed copies each cell
// up in S_COPY_RD and S_COPY_WR, one read and one write per copied cell on the single grid
// memory port pair, then fills the bottom row in S_FILL.
// Requests are taken one at a time, only in S_IDLE, and one is taken while a result waits.
// Reset (rst_n low, synchronous) clears control state, then a pass fills the grid with spaces.
`default_nettype none

module text_console_cell_writer_top
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 50
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_req_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_rsp_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;

  localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [ARG_W-1:0] COLS8 = ARG_W'(COLS);
  localparam logic [ARG_W-1:0] ROWS8 = ARG_W'(ROWS);
  localparam logic [CFG_DATA_W-1:0] ROW_MAX6 = CFG_DATA_W'(ROWS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_COPY_RD,
    S_COPY_WR,
    S_FILL,
    S_READ,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] end_r, end_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  char_t         cell_r, cell_nxt;
  logic          cell_ok_r, cell_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_rsp_t      out_data_r, out_data_nxt;
  logic          scr_en_r;
  logic [CFG_DATA_W-1:0] scr_top_r;
  logic [CFG_DATA_W-1:0] scr_bot_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  char_t         mem_wdata;
  logic [AW-1:0] mem_raddr;
  char_t         mem_rdata;

  tcw_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Decode command arguments
  logic            col_neg, row_neg, stop_neg;
  logic [ARG_W-2:0] col_u, row_u, stop_u;
  logic            col_on, row_on, stop_on;
  logic [RW-1:0]   top_sat, bot_sat, row_inc, row_up;
  logic            at_last, do_scroll, col_last, row_last;

  assign col_neg  = in_data.col_arg[ARG_W-1];
  assign row_neg  = in_data.row_arg[ARG_W-1];
  assign stop_neg = in_data.row_stop[ARG_W-1];
  assign col_u    = in_data.col_arg[ARG_W-2:0];
  assign row_u    = in_data.row_arg[ARG_W-2:0];
  assign stop_u   = in_data.row_stop[ARG_W-2:0];
  assign col_on   = !col_neg && ({1'b0, col_u} < COLS8);
  assign row_on   = !row_neg && ({1'b0, row_u} < ROWS8);
  assign stop_on  = !stop_neg && ({1'b0, stop_u} < ROWS8);

  // Saturate the scroll region to the grid and decide a scroll on line feed
  assign top_sat   = (scr_top_r > ROW_MAX6) ? ROW_LAST : RW'(scr_top_r);
  assign bot_sat   = (scr_bot_r > ROW_MAX6) ? ROW_LAST : RW'(scr_bot_r);
  assign at_last   = (cur_row_r == ROW_LAST);
  assign row_inc   = at_last ? cur_row_r : RW'(cur_row_r + RW'(1));
  assign do_scroll = scr_en_r && (bot_sat >= top_sat) && ((row_inc > bot_sat) || at_last);

  // Row and column walker shared by clear, copy and fill passes
  assign row_up   = RW'(row_r + RW'(1));
  assign col_last = (col_r == COL_LAST);
  assign row_last = (row_r == end_r);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    end_nxt       = end_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    cell_nxt      = cell_r;
    cell_ok_nxt   = cell_ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = {row_r, col_r};
    mem_wdata     = CHAR_SPACE;
    mem_raddr     = {row_up, col_r};

    case (state_r)
      // Fill the grid with spaces after reset
      S_CLEAR: begin
        mem_we = 1'b1;
        if (col_last) begin
          col_nxt = '0;
          row_nxt = row_up;
          if (row_last) begin
            state_nxt = S_IDLE;
          end
        end else begin
          col_nxt = CW'(col_r + CW'(1));
        end
      end

      // Take a request and start its work
      S_IDLE: begin
        if (in_valid) begin
          cell_nxt    = '0;
          cell_ok_nxt = 1'b0;
          state_nxt   = S_DONE;
          case (in_data.func)
            FUNC_PUT: begin
              if (in_data.char_code == CHAR_BACKSPACE || in_data.char_code == CHAR_DELETE) begin
                if (cur_col_r != '0) begin
                  cur_col_nxt = CW'(cur_col_r - CW'(1));
                end else if (cur_row_r != '0) begin
                  cur_row_nxt = RW'(cur_row_r - RW'(1));
                  cur_col_nxt = COL_LAST;
                end
              end else begin
                if (in_data.char_code != CHAR_NEWLINE) begin
                  mem_we    = 1'b1;
                  mem_waddr = {cur_row_r, cur_col_r};
                  mem_wdata = in_data.char_code;
                end
                if (in_data.char_code == CHAR_NEWLINE || cur_col_r == COL_LAST) begin
                  // Line feed, with scroll of the region when needed
                  cur_col_nxt = '0;
                  if (do_scroll) begin
                    cur_row_nxt = bot_sat;
                    col_nxt     = '0;
                    end_nxt     = bot_sat;
                    if (top_sat < bot_sat) begin
                      row_nxt   = top_sat;
                      state_nxt = S_COPY_RD;
                    end else begin
                      row_nxt   = bot_sat;
                      state_nxt = S_FILL;
                    end
                  end else begin
                    cur_row_nxt = row_inc;
                  end
                end else begin
                  cur_col_nxt = CW'(cur_col_r + CW'(1));
                end
              end
            end
            FUNC_MOVE: begin
              if (col_neg) begin
                cur_col_nxt = '0;
              end else if (!col_on) begin
                cur_col_nxt = COL_LAST;
              end else begin
                cur_col_nxt = CW'(col_u);
              end
              if (row_neg) begin
                cur_row_nxt = '0;
              end else if (!row_on) begin
                cur_row_nxt = ROW_LAST;
              end else begin
                cur_row_nxt = RW'(row_u);
              end
            end
            FUNC_CLR_SCR: begin
              cur_col_nxt = '0;
              cur_row_nxt = '0;
              row_nxt     = '0;
              col_nxt     = '0;
              end_nxt     = ROW_LAST;
              state_nxt   = S_FILL;
            end
            FUNC_CLR_ROWS: begin
              if (row_on && stop_on && (row_u < stop_u)) begin
                row_nxt   = RW'(row_u);
                col_nxt   = '0;
                end_nxt   = RW'(stop_u - (ARG_W-1)'(1));
                state_nxt = S_FILL;
              end
            end
            FUNC_READ: begin
              if (col_on && row_on) begin
                mem_raddr   = {RW'(row_u), CW'(col_u)};
                cell_ok_nxt = 1'b1;
                state_nxt   = S_READ;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Copy one cell from the row below
      S_COPY_RD: begin
        state_nxt = S_COPY_WR;
      end

      S_COPY_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        state_nxt = S_COPY_RD;
        if (col_last) begin
          col_nxt = '0;
          row_nxt = row_up;
          if (row_up == end_r) begin
            state_nxt = S_FILL;
          end
        end else begin
          col_nxt = CW'(col_r + CW'(1));
        end
      end

      // Fill rows row_r through end_r with spaces
      S_FILL: begin
        mem_we = 1'b1;
        if (col_last) begin
          col_nxt = '0;
          row_nxt = row_up;
          if (row_last) begin
            state_nxt = S_DONE;
          end
        end else begin
          col_nxt = CW'(col_r + CW'(1));
        end
      end

      // Capture the read data
      S_READ: begin
        cell_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.cursor_col = ccol_t'(cur_col_r);
          out_data_nxt.cursor_row = crow_t'(cur_row_r);
          out_data_nxt.cell_char  = cell_r;
          out_data_nxt.cell_valid = cell_ok_r;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, cursor, configuration and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      end_r       <= ROW_LAST;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      cell_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
      scr_en_r    <= 1'b0;
      scr_top_r   <= '0;
      scr_bot_r   <= SCROLL_BOT_RST;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      end_r       <= end_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      cell_ok_r   <= cell_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCROLL_EN:  scr_en_r  <= cfg_data[0];
          CFG_SCROLL_TOP: scr_top_r <= cfg_data;
          CFG_SCROLL_BOT: scr_bot_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // Cursor stays on the grid
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r <= COL_LAST) && (cur_row_r <= ROW_LAST))
    else $error("cursor off the grid");

  // A new result appears only after the sequencer finished a request
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result without finished request");

  // While idle the grid is written only by an accepted put char
  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && mem_we) |-> (in_valid && in_data.func == FUNC_PUT))
    else $error("stray grid write while idle");

  // No request is taken right after reset while the grid is cleared
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("request taken during clearing pass");
`endif

endmodule

`default_nettype wire
